/* sv/ipfr_pkg.sv */
// Package for the IPv4 fragment reassembly tracker: codes, states and sizes.
`default_nettype none
package ipfr_pkg;
	localparam int MAX_FRAGMENTS_DEF = 64;
	localparam logic [17:0] MAX_DATAGRAM = 18'd65535;

	localparam logic [2:0] ST_PROGRESS = 3'd0;
	localparam logic [2:0] ST_COMPLETE = 3'd1;
	localparam logic [2:0] ST_INVALID  = 3'd2;
	localparam logic [2:0] ST_OVERLAP  = 3'd3;
	localparam logic [2:0] ST_OVERSIZE = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_EXPIRED  = 3'd6;
	localparam logic [2:0] ST_IDLE     = 3'd7;

	localparam int FO_DF = 14;
	localparam int FO_MF = 13;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_APPEND,
		S_RESP
	} state_t;
endpackage
`default_nettype wire

/* sv/ipfr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ipfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/ipv4_fragment_reassembly_tracker.sv */
// Top level of the IPv4 fragment reassembly tracker for one datagram context.
// A fragment is evaluated, then scanned against the stored intervals (up to MAX_FRAGMENTS),
//   one interval is read from RAM per cycle in the scan, then appended, and its result is offered.
// Expire words and fragments rejected on length skip the scan; an overlap ends the scan early.
// Only one word is in flight: in_stall stays high until the result has been handed over.
// Reset clears the context and handshake state at once; the interval RAM is not cleared,
//   entries at or above the interval count are never used.
`default_nettype none
module ipv4_fragment_reassembly_tracker
	import ipfr_pkg::*;
#(
	parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [15:0] flags_offset_word,
	input  wire logic [15:0] packet_length,
	input  wire logic [5:0]  header_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      total_length,
	output logic             dont_fragment,
	output logic [15:0]      largest_df_fragment,
	output logic             send_time_exceeded
);
	localparam int IW = $clog2(MAX_FRAGMENTS);
	localparam int CW = $clog2(MAX_FRAGMENTS + 1);
	localparam int RW = 33;

	state_t state_q, state_d;

	// captured input word
	logic        kind_q;
	logic [15:0] fo_q;
	logic [15:0] plen_q;
	logic [5:0]  ihl_q;
	logic [16:0] end_q;       // interval end (trimmed for MF fragments), valid from the scan on

	// datagram context
	logic [CW-1:0] cnt_q;
	logic [16:0]   exp_q;
	logic [16:0]   br_q;
	logic          fs_q;
	logic          ls_q;
	logic [5:0]    hh_q;
	logic [16:0]   mdf_q;

	// scan control
	logic [CW-1:0] idx_q;
	logic          chk_q;

	// pending result
	logic [2:0]  r_st_q;
	logic [15:0] r_tot_q;
	logic        r_df_q;
	logic [15:0] r_mdf_q;
	logic        r_ste_q;

	logic        accept;
	logic        res_ready;
	logic [15:0] offset;
	logic [16:0] raw_end;
	logic [16:0] trim_end;
	logic        mf, df;
	logic [RW-1:0] rd_data;
	logic [15:0] rd_start;
	logic [16:0] rd_end;
	logic        overlap;
	logic        mem_we;
	logic [16:0] size;
	logic [16:0] br_n;
	logic        fs_n;
	logic [5:0]  hh_n;
	logic [16:0] dfsz;
	logic [16:0] mdf_n;
	logic [17:0] total;
	logic        complete;
	logic        full;

	assign accept    = in_valid && !in_stall;
	assign res_ready = !out_valid || !out_stall;
	assign in_stall  = (state_q != S_IDLE);

	assign offset   = {fo_q[12:0], 3'b000};
	assign mf       = fo_q[FO_MF];
	assign df       = fo_q[FO_DF];
	assign raw_end  = {1'b0, offset} + {1'b0, plen_q} - {11'd0, ihl_q};
	assign trim_end = {raw_end[16:3], 3'b000};

	assign rd_start = rd_data[RW-1:17];
	assign rd_end   = rd_data[16:0];
	assign overlap  = ({1'b0, offset} < rd_end) && (end_q > {1'b0, rd_start});

	// append datapath
	assign full     = (cnt_q >= CW'(MAX_FRAGMENTS));
	assign mem_we   = (state_q == S_APPEND) && !full;
	assign size     = end_q - {1'b0, offset};
	assign br_n     = br_q + size;
	assign fs_n     = fs_q || (offset == 16'd0);
	assign hh_n     = (offset == 16'd0) ? ihl_q : hh_q;
	assign dfsz     = size + {11'd0, ihl_q};
	assign mdf_n    = (df && dfsz > mdf_q) ? dfsz : mdf_q;
	assign complete = fs_n && ls_q && (br_n == exp_q);
	assign total    = {12'd0, hh_n} + {1'b0, exp_q};

	ipfr_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_FRAGMENTS),
		.AW(IW)
	) u_intervals (
		.clk(clk),
		.we(mem_we),
		.waddr(cnt_q[IW-1:0]),
		.wdata({offset, end_q}),
		.raddr(idx_q[IW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_d = S_EVAL;
			S_EVAL: begin
				state_d = S_RESP;
				if (!kind_q && plen_q >= {10'd0, ihl_q}) begin
					if (!mf) begin
						if (!(raw_end < exp_q || (ls_q && raw_end != exp_q))
						    && raw_end > {1'b0, offset}) begin
							state_d = S_SCAN;
						end
					end else if (!(trim_end > exp_q && ls_q)
					             && trim_end > {1'b0, offset}) begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (chk_q && overlap) begin
					state_d = S_RESP;
				end else if (idx_q >= cnt_q) begin
					state_d = S_APPEND;
				end
			end
			S_APPEND: state_d = S_RESP;
			S_RESP:   if (res_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// context, scan and result bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			exp_q <= '0;
			br_q  <= '0;
			fs_q  <= 1'b0;
			ls_q  <= 1'b0;
			hh_q  <= '0;
			mdf_q <= '0;
			idx_q <= '0;
			chk_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_EVAL: begin
					idx_q <= '0;
					chk_q <= 1'b0;
					if (kind_q) begin
						if (cnt_q != '0 || exp_q != '0 || ls_q || fs_q) begin
							cnt_q <= '0;
							exp_q <= '0;
							br_q  <= '0;
							fs_q  <= 1'b0;
							ls_q  <= 1'b0;
							hh_q  <= '0;
							mdf_q <= '0;
						end
					end else if (plen_q >= {10'd0, ihl_q}) begin
						if (!mf) begin
							if (!(raw_end < exp_q || (ls_q && raw_end != exp_q))) begin
								ls_q  <= 1'b1;
								exp_q <= raw_end;
							end
						end else if (trim_end > exp_q && !ls_q) begin
							exp_q <= trim_end;
						end
					end
				end
				S_SCAN: begin
					if (chk_q && overlap) begin
						cnt_q <= '0;
						exp_q <= '0;
						br_q  <= '0;
						fs_q  <= 1'b0;
						ls_q  <= 1'b0;
						hh_q  <= '0;
						mdf_q <= '0;
					end else if (idx_q < cnt_q) begin
						idx_q <= idx_q + CW'(1);
						chk_q <= 1'b1;
					end else begin
						chk_q <= 1'b0;
					end
				end
				S_APPEND: begin
					if (!full) begin
						if (complete) begin
							cnt_q <= '0;
							exp_q <= '0;
							br_q  <= '0;
							fs_q  <= 1'b0;
							ls_q  <= 1'b0;
							hh_q  <= '0;
							mdf_q <= '0;
						end else begin
							cnt_q <= cnt_q + CW'(1);
							br_q  <= br_n;
							fs_q  <= fs_n;
							hh_q  <= hh_n;
							mdf_q <= mdf_n;
						end
					end
				end
				default: ;
			endcase
			if (state_q == S_RESP && res_ready) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			fo_q   <= flags_offset_word;
			plen_q <= packet_length;
			ihl_q  <= header_length;
		end
		if (state_q == S_EVAL) begin
			end_q   <= mf ? trim_end : raw_end;
			r_tot_q <= '0;
			r_df_q  <= 1'b0;
			r_mdf_q <= '0;
			if (kind_q) begin
				if (cnt_q != '0 || exp_q != '0 || ls_q || fs_q) begin
					r_st_q  <= ST_EXPIRED;
					r_ste_q <= fs_q;
				end else begin
					r_st_q  <= ST_IDLE;
					r_ste_q <= 1'b0;
				end
			end else begin
				r_st_q  <= ST_INVALID;
				r_ste_q <= 1'b0;
			end
		end
		if (state_q == S_SCAN && chk_q && overlap) begin
			r_st_q <= ST_OVERLAP;
		end
		if (state_q == S_APPEND) begin
			if (full) begin
				r_st_q <= ST_FULL;
			end else if (!complete) begin
				r_st_q <= ST_PROGRESS;
			end else if (total > MAX_DATAGRAM) begin
				r_st_q <= ST_OVERSIZE;
			end else begin
				r_st_q  <= ST_COMPLETE;
				r_tot_q <= total[15:0];
				r_df_q  <= (mdf_n != '0);
				r_mdf_q <= mdf_n[15:0];
			end
		end
		if (state_q == S_RESP && res_ready) begin
			status              <= r_st_q;
			total_length        <= r_tot_q;
			dont_fragment       <= r_df_q;
			largest_df_fragment <= r_mdf_q;
			send_time_exceeded  <= r_ste_q;
		end
	end
endmodule
`default_nettype wire

/* sv/ipfr_checker.sv */
// Port-level assertions for the reassembly tracker and their bind.
`default_nettype none
module ipfr_checker
	import ipfr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [15:0] total_length,
	input wire logic        dont_fragment,
	input wire logic [15:0] largest_df_fragment,
	input wire logic        send_time_exceeded
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_COMPLETE |->
			total_length == 16'd0 && !dont_fragment && largest_df_fragment == 16'd0)
		else $error("length fields set without completion");

	a_ste: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_EXPIRED |-> !send_time_exceeded)
		else $error("time exceeded outside expiry");

	a_df: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_COMPLETE |-> dont_fragment == (largest_df_fragment != 16'd0))
		else $error("DF flag disagrees with largest DF fragment");
endmodule

bind ipv4_fragment_reassembly_tracker ipfr_checker u_ipfr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.total_length(total_length),
	.dont_fragment(dont_fragment),
	.largest_df_fragment(largest_df_fragment),
	.send_time_exceeded(send_time_exceeded)
);
`default_nettype wire

/* sim/ipv4_fragment_reassembly_tracker_tb.sv */
// Self-checking testbench for the IPv4 fragment reassembly tracker.
`timescale 1ns / 100ps
`default_nettype none
module ipv4_fragment_reassembly_tracker_tb;
	import ipfr_pkg::*;

	localparam int NFRAG = MAX_FRAGMENTS_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_WORDS = 1800;

	typedef struct packed {
		logic        kind;
		logic [15:0] fo;
		logic [15:0] plen;
		logic [5:0]  hlen;
	} frag_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] total;
		logic        df;
		logic [15:0] largest;
		logic        ste;
	} verdict_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic kind;
	logic [15:0] flags_offset_word, packet_length;
	logic [5:0] header_length;
	logic out_valid, out_stall;
	logic [2:0] status;
	logic [15:0] total_length, largest_df_fragment;
	logic dont_fragment, send_time_exceeded;

	ipv4_fragment_reassembly_tracker DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .flags_offset_word(flags_offset_word),
		.packet_length(packet_length), .header_length(header_length),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .total_length(total_length),
		.dont_fragment(dont_fragment), .largest_df_fragment(largest_df_fragment),
		.send_time_exceeded(send_time_exceeded)
	);

	// predictor's copy of the datagram context
	logic [16:0] iv_lo [NFRAG];
	logic [16:0] iv_hi [NFRAG];
	int          iv_count;
	logic [16:0] exp_len, got_bytes, big_df;
	logic        head_in, tail_in;
	logic [5:0]  head_hlen;

	frag_word_t pending_words[$];
	verdict_t   expected_verdicts[$];
	int  mismatches = 0;
	int  cycles = 0;
	int  sent = 0;
	int  tx_gap = 0;
	int  rx_hold = 0;
	frag_word_t tx_w;
	verdict_t   want_v, got_v;

	function automatic void wipe_context();
		iv_count = 0; exp_len = '0; got_bytes = '0;
		head_in = 1'b0; tail_in = 1'b0; head_hlen = '0; big_df = '0;
	endfunction

	function automatic verdict_t mk(logic [2:0] st);
		verdict_t v;
		v = '0;
		v.status = st;
		return v;
	endfunction

	// works out the verdict for one word and advances the context
	function automatic verdict_t reassemble(frag_word_t w);
		logic [16:0] off, stop, sz;
		logic [17:0] tot;
		logic [16:0] mdf;
		bit ste;
		verdict_t v;
		if (w.kind) begin
			if (iv_count == 0 && exp_len == '0 && !tail_in && !head_in)
				return mk(ST_IDLE);
			ste = head_in;
			wipe_context();
			v = mk(ST_EXPIRED);
			v.ste = ste;
			return v;
		end
		if (w.plen < {10'd0, w.hlen})
			return mk(ST_INVALID);
		off = {1'b0, w.fo[12:0], 3'b000};
		stop = off + {1'b0, w.plen} - {11'd0, w.hlen};
		if (!w.fo[FO_MF]) begin
			if (stop < exp_len || (tail_in && stop != exp_len))
				return mk(ST_INVALID);
			tail_in = 1'b1;
			exp_len = stop;
		end else begin
			stop[2:0] = 3'b000;
			if (stop > exp_len) begin
				if (tail_in)
					return mk(ST_INVALID);
				exp_len = stop;
			end
		end
		if (stop <= off)
			return mk(ST_INVALID);
		for (int i = 0; i < iv_count; i++)
			if (off < iv_hi[i] && stop > iv_lo[i]) begin
				wipe_context();
				return mk(ST_OVERLAP);
			end
		if (iv_count >= NFRAG)
			return mk(ST_FULL);
		iv_lo[iv_count] = off;
		iv_hi[iv_count] = stop;
		iv_count++;
		sz = stop - off;
		got_bytes = got_bytes + sz;
		if (off == '0) begin
			head_in = 1'b1;
			head_hlen = w.hlen;
		end
		if (w.fo[FO_DF] && sz + {11'd0, w.hlen} > big_df)
			big_df = sz + {11'd0, w.hlen};
		if (head_in && tail_in && got_bytes == exp_len) begin
			mdf = big_df;
			tot = {12'd0, head_hlen} + {1'b0, exp_len};
			wipe_context();
			if (tot > MAX_DATAGRAM)
				return mk(ST_OVERSIZE);
			v = mk(ST_COMPLETE);
			v.total = tot[15:0];
			v.df = (mdf != '0);
			v.largest = mdf[15:0];
			return v;
		end
		return mk(ST_PROGRESS);
	endfunction

	function automatic frag_word_t frag(int off8, bit mf, bit df, int paylen, int hl);
		frag_word_t w;
		w.kind = 1'b0;
		w.fo = {1'($urandom_range(0, 1)), df, mf, 13'(off8)};
		w.hlen = 6'(hl);
		w.plen = 16'(paylen + hl);
		return w;
	endfunction

	function automatic frag_word_t expire_word();
		frag_word_t w;
		w.kind = 1'b1;
		w.fo = 16'($urandom);
		w.plen = 16'($urandom);
		w.hlen = 6'($urandom_range(20, 60));
		return w;
	endfunction

	function automatic frag_word_t noise_word();
		frag_word_t w;
		w.kind = 1'b0;
		w.fo = 16'($urandom);
		w.plen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
		w.hlen = 6'($urandom_range(20, 60));
		return w;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 80);
	endfunction

	task automatic report_mismatch(string what, verdict_t want, verdict_t got);
		mismatches++;
		$display("mismatch at cycle %0d: %s want %h got %h", cycles, what, want, got);
	endtask

	// one datagram split into often shuffled, mostly well-formed fragments
	task automatic queue_datagram();
		int nf, units, pos, j, t, skip, hl;
		bit big, dfs, tl;
		int offs[$], lens[$];
		bit lasts[$];
		big = ($urandom_range(0, 14) == 0);
		if (big)
			nf = 9;
		else
			nf = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 6);
		pos = 0;
		dfs = 1'($urandom_range(0, 1));
		for (int i = 0; i < nf; i++) begin
			if (big)
				units = $urandom_range(905, 935);
			else
				units = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 900) :
					$urandom_range(1, 40);
			offs.push_back(pos);
			lens.push_back(units * 8);
			lasts.push_back(i == nf - 1);
			pos += units;
		end
		// last fragment length need not be a multiple of 8
		lens[nf - 1] = lens[nf - 1] - $urandom_range(0, 7);
		if ($urandom_range(0, 2) != 0) begin
			for (int i = nf - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = offs[i]; offs[i] = offs[j]; offs[j] = t;
				t = lens[i]; lens[i] = lens[j]; lens[j] = t;
				tl = lasts[i]; lasts[i] = lasts[j]; lasts[j] = tl;
			end
		end
		skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nf - 1) : -1;
		for (int i = 0; i < nf; i++) begin
			if (i != skip) begin
				hl = $urandom_range(20, 60);
				pending_words.push_back(frag(offs[i], !lasts[i],
					dfs && ($urandom_range(0, 1) == 1), lens[i], hl));
				// occasional repeat of this or an earlier fragment
				if ($urandom_range(0, 29) == 0) begin
					j = $urandom_range(0, i);
					pending_words.push_back(frag(offs[j], !lasts[j], 1'b0, lens[j], hl));
				end
			end
		end
		if (skip >= 0)
			pending_words.push_back(expire_word());
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= 1'b0;
			flags_offset_word <= '0;
			packet_length <= '0;
			header_length <= '0;
			tx_gap = 0;
		end else if (!in_valid || !in_stall) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (sent % 400 == 200 && expected_verdicts.size() != 0) begin
				// let the block drain completely
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				tx_w = pending_words.pop_front();
				in_valid <= 1'b1;
				kind <= tx_w.kind;
				flags_offset_word <= tx_w.fo;
				packet_length <= tx_w.plen;
				header_length <= tx_w.hlen;
				expected_verdicts.push_back(reassemble(tx_w));
				sent++;
				tx_gap = gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold = 0;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end else if (cycles == 2000 || $urandom_range(0, 999) == 0) begin
			rx_hold = $urandom_range(300, 600);
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < 30) begin
			rx_hold = gap_len();
			out_stall <= (rx_hold != 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_v = {status, total_length, dont_fragment, largest_df_fragment,
				send_time_exceeded};
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected result", '0, got_v);
			end else begin
				want_v = expected_verdicts.pop_front();
				if (got_v != want_v)
					report_mismatch("result", want_v, got_v);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int r;
		wipe_context();
		while (pending_words.size() < N_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				pending_words.push_back(noise_word());
			else if (r < 12)
				pending_words.push_back(expire_word());
			else
				queue_datagram();
		end
		while (arst_n !== 1'b1)
			@(posedge clk);
		while (pending_words.size() != 0 || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

/* ipv4_fragment_reassembly_tracker.f */
sv/ipfr_pkg.sv
sv/ipfr_ram.sv
sv/ipv4_fragment_reassembly_tracker.sv
sv/ipfr_checker.sv
sim/ipv4_fragment_reassembly_tracker_tb.sv
